### rtl/silq_pkg.sv
package silq_pkg;

  localparam int MAX_INPUTS_DEF = 8;
  localparam int INDEX_W        = 3;
  localparam int CODE_W         = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CODE_W-1:0] LOCK_THR_RST   = 4'd3;
  localparam logic [CODE_W-1:0] UNLOCK_THR_RST = 4'd2;
  localparam logic [CODE_W-1:0] IN_USE_RST     = 4'd8;
  localparam logic [CODE_W-1:0] NO_SIG_RST     = 4'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCK_THRESHOLD   = 2'd0,
    CFG_UNLOCK_THRESHOLD = 2'd1,
    CFG_INPUTS_IN_USE    = 2'd2,
    CFG_NO_SIGNAL_RATE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] sample_index;
    logic [CODE_W-1:0]  rate_code;
    logic [CODE_W-1:0]  geometry;
    logic               progressive;
    logic               is_3g;
    logic               is_3g_level_b;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic               accepted;
    logic               locked;
    logic               lock_event;
    logic               unlock_event;
    logic [CODE_W-1:0]  locked_rate;
    logic [CODE_W-1:0]  locked_geometry;
    logic               locked_progressive;
    logic               locked_3g;
    logic               locked_3g_b;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CODE_W-1:0]    value;
  } cfg_beat_t;

  // 11-bit status word, rate in the low nibble
  typedef struct packed {
    logic              is_3g_b;
    logic              is_3g;
    logic              progressive;
    logic [CODE_W-1:0] geometry;
    logic [CODE_W-1:0] rate;
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] cnt;
    logic              hit;
  } bump_t;

  function automatic logic status_match(status_t a, status_t b, logic [CODE_W-1:0] no_sig);
    logic res;
    res = (a.rate != no_sig) && (b.rate != no_sig) && (a == b);
    return res;
  endfunction

  // saturating run counter, hit only on the step that reaches the threshold
  function automatic bump_t bump(logic [CODE_W-1:0] cnt, logic [CODE_W-1:0] thr,
                                 logic same);
    bump_t res;
    res.cnt = cnt;
    res.hit = 1'b0;
    if (!same) begin
      res.cnt = '0;
    end else if (cnt < thr) begin
      res.cnt = cnt + 1'b1;
      res.hit = (res.cnt >= thr);
    end
    return res;
  endfunction

endpackage

### rtl/silq_chan_if.sv
interface silq_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/sdi_input_lock_qualifier.sv
// accepted beats pass the input register, then the result register, to out_ch
// throughput: one status sample per cycle unless out_ch stalls, with per-input
//   state updated as the sample leaves the input register, so a repeat of the
//   same input in the next cycle sees the new state without a bubble
// reset (rst_n low, synchronous): both pipeline registers empty, all inputs
//   unlocked with counters and stored status zero, registers at their defaults
module sdi_input_lock_qualifier #(
  parameter int MAX_INPUTS = silq_pkg::MAX_INPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  silq_chan_if.sink   in_ch,
  silq_chan_if.source out_ch,
  silq_chan_if.sink   cfg_ch
);

  localparam int IDX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int EXT_W = (IDX_W > silq_pkg::INDEX_W) ? IDX_W : silq_pkg::INDEX_W;
  localparam int CW    = silq_pkg::CODE_W;

  // configuration registers
  logic [CW-1:0] lock_thr_r;
  logic [CW-1:0] unlock_thr_r;
  logic [CW-1:0] in_use_r;
  logic [CW-1:0] no_sig_r;

  // per-input state, one entry per monitored input
  silq_pkg::status_t prev_r  [MAX_INPUTS];
  silq_pkg::status_t lstat_r [MAX_INPUTS];
  logic [CW-1:0]     mcnt_r  [MAX_INPUTS];
  logic [CW-1:0]     ucnt_r  [MAX_INPUTS];
  logic              lflag_r [MAX_INPUTS];

  // input register and result register
  logic                s1_vld_r;
  silq_pkg::in_item_t  s1_item_r;
  logic                out_vld_r;
  silq_pkg::out_item_t out_item_r;

  logic                adv;
  logic                in_fire;
  logic [EXT_W-1:0]    idx_ext;
  logic [IDX_W-1:0]    ix;
  logic                acc;
  silq_pkg::status_t   smp;
  silq_pkg::bump_t     mb;
  silq_pkg::bump_t     ub;
  logic                lflag_nxt;
  silq_pkg::status_t   lstat_nxt;
  logic                lev;
  logic                uev;
  silq_pkg::out_item_t out_item_nxt;

  // ---------------------------------------------------------------- handshake
  // the sample in the input register moves on whenever the result register
  // is empty or its beat is being taken this cycle
  assign adv         = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_item_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_thr_r   <= silq_pkg::LOCK_THR_RST;
      unlock_thr_r <= silq_pkg::UNLOCK_THR_RST;
      in_use_r     <= silq_pkg::IN_USE_RST;
      no_sig_r     <= silq_pkg::NO_SIG_RST;
    end else if (cfg_ch.valid) begin
      case (silq_pkg::cfg_reg_t'(cfg_ch.data.index))
        silq_pkg::CFG_LOCK_THRESHOLD:   lock_thr_r   <= cfg_ch.data.value;
        silq_pkg::CFG_UNLOCK_THRESHOLD: unlock_thr_r <= cfg_ch.data.value;
        silq_pkg::CFG_INPUTS_IN_USE:    in_use_r     <= cfg_ch.data.value;
        silq_pkg::CFG_NO_SIGNAL_RATE:   no_sig_r     <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- qualify
  // index widened or trimmed to the state depth; an index beyond the depth
  // is never accepted, so the trimmed address is only ever read
  assign idx_ext = EXT_W'(s1_item_r.sample_index);
  assign ix      = idx_ext[IDX_W-1:0];
  assign acc     = (CW'(s1_item_r.sample_index) < in_use_r) &&
                   (32'(s1_item_r.sample_index) < 32'(MAX_INPUTS));

  assign smp = {s1_item_r.is_3g_level_b, s1_item_r.is_3g, s1_item_r.progressive,
                s1_item_r.geometry, s1_item_r.rate_code};

  always_comb begin
    // unlock run counts samples that differ from the locked status,
    // lock run counts samples equal to the previous sample
    ub = silq_pkg::bump(ucnt_r[ix], unlock_thr_r,
                        !silq_pkg::status_match(smp, lstat_r[ix], no_sig_r));
    mb = silq_pkg::bump(mcnt_r[ix], lock_thr_r,
                        silq_pkg::status_match(smp, prev_r[ix], no_sig_r));

    lflag_nxt = lflag_r[ix];
    lstat_nxt = lstat_r[ix];
    lev       = 1'b0;
    uev       = 1'b0;
    // unlock first, so both can fire on one sample and end locked to it
    if (lflag_nxt && ub.hit) begin
      lflag_nxt = 1'b0;
      uev       = 1'b1;
    end
    if (!lflag_nxt && mb.hit) begin
      lflag_nxt = 1'b1;
      lstat_nxt = smp;
      lev       = 1'b1;
    end

    out_item_nxt              = '0;
    out_item_nxt.result_index = s1_item_r.sample_index;
    if (acc) begin
      out_item_nxt.accepted           = 1'b1;
      out_item_nxt.locked             = lflag_nxt;
      out_item_nxt.lock_event         = lev;
      out_item_nxt.unlock_event       = uev;
      out_item_nxt.locked_rate        = lstat_nxt.rate;
      out_item_nxt.locked_geometry    = lstat_nxt.geometry;
      out_item_nxt.locked_progressive = lstat_nxt.progressive;
      out_item_nxt.locked_3g          = lstat_nxt.is_3g;
      out_item_nxt.locked_3g_b        = lstat_nxt.is_3g_b;
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
        prev_r[i]  <= '0;
        lstat_r[i] <= '0;
        mcnt_r[i]  <= '0;
        ucnt_r[i]  <= '0;
        lflag_r[i] <= 1'b0;
      end
    end else if (adv && acc) begin
      prev_r[ix]  <= smp;
      lstat_r[ix] <= lstat_nxt;
      mcnt_r[ix]  <= mb.cnt;
      ucnt_r[ix]  <= ub.cnt;
      lflag_r[ix] <= lflag_nxt;
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_ch.data;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  // ---------------------------------------------------------------- checks
  // events only come from inputs that are in use
  a_event_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_item_r.lock_event || out_item_r.unlock_event)
      |-> out_item_r.accepted)
    else $error("event reported for an input not in use");

  // a lock event always leaves the input locked
  a_lock_ev_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.lock_event |-> out_item_r.locked)
    else $error("lock event without lock flag");

  // a lone unlock event leaves the input unlocked
  a_unlock_ev_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.unlock_event && !out_item_r.lock_event
      |-> !out_item_r.locked)
    else $error("unlock event with lock flag still set");

  // a blocked sample stays in the input register untouched
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !adv |=> s1_vld_r && $stable(s1_item_r))
    else $error("input register lost or changed a blocked sample");

endmodule
